### sv/ppc_privileged_insn_emulator_top_macros.svh
// Assertion macros shared by the emulator's checking code.
`ifndef PPC_PRIVILEGED_INSN_EMULATOR_TOP_MACROS_SVH
`define PPC_PRIVILEGED_INSN_EMULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

  localparam logic [31:0] OP_MASK  = 32'hfc0007fe;
  localparam logic [31:0] OP_MTSPR = 32'h7c0003a6;
  localparam logic [31:0] OP_MFSPR = 32'h7c0002a6;
  localparam logic [31:0] OP_MTMSR = 32'h7c000124;
  localparam logic [31:0] OP_MFMSR = 32'h7c0000a6;
  localparam logic [31:0] OP_MFSR  = 32'h7c0004a6;
  localparam logic [31:0] OP_RFI   = 32'h4c000064;

  localparam logic [31:0] PVR_RESET    = 32'h00040103;
  localparam logic [31:0] MSR_RESET    = 32'h00000030;
  localparam logic [31:0] MSR_MMU_MASK = 32'h00000030;

  localparam logic [9:0] SPR_SDR1 = 10'd25;
  localparam logic [9:0] SPR_SRR0 = 10'd26;
  localparam logic [9:0] SPR_SRR1 = 10'd27;
  localparam logic [9:0] SPR_PVR  = 10'd287;
  // BAT words are SPRs 528..543 and SPRGs are 272..275; both ranges are aligned.
  localparam logic [5:0] SPR_BAT_PREFIX  = 6'h21;
  localparam logic [7:0] SPR_SPRG_PREFIX = 8'h44;

  localparam logic [1:0] ST_HANDLED      = 2'd0;
  localparam logic [1:0] ST_NOT_EMULATED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN_INSN = 2'd2;
  localparam logic [1:0] ST_BAD_SPR      = 2'd3;

  typedef struct packed {
    logic        is_program_trap;
    logic        mode_64bit;
    logic [31:0] insn;
    logic [31:0] pc;
    logic [31:0] source_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] next_pc;
    logic        mmu_changed;
    logic        mmu_enabled;
  } rsp_t;

  function automatic logic mmu_on(input logic [31:0] msr);
    return (msr & MSR_MMU_MASK) != 32'd0;
  endfunction

endpackage

### sv/ppe_in_stage.sv
`timescale 1ns / 1ps

module ppe_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ppe_pkg::req_t req,
  input  logic          advance,
  output logic          held_valid,
  output ppe_pkg::req_t held
);

  assign req_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req;
    end
  end

endmodule

### sv/ppe_core.sv
`timescale 1ns / 1ps

module ppe_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data,
  input  logic          fire,
  input  ppe_pkg::req_t item,
  output ppe_pkg::rsp_t result
);

  logic [31:0] pvr;
  logic [31:0] msr;
  logic [31:0] srr0;
  logic [31:0] srr1;
  logic [31:0] sdr1;
  logic [31:0] sprg [4];
  logic [31:0] bat [16];

  logic [31:0] op;
  logic [9:0]  spr;
  logic        spr_is_bat;
  logic        spr_is_sprg;
  logic [31:0] msr_next;
  logic        msr_we;
  logic        srr0_we;
  logic        srr1_we;
  logic        sdr1_we;
  logic        sprg_we;
  logic        bat_we;

  assign op          = item.insn & ppe_pkg::OP_MASK;
  // The SPR number is encoded with its two 5-bit halves swapped.
  assign spr         = {item.insn[15:11], item.insn[20:16]};
  assign spr_is_bat  = spr[9:4] == ppe_pkg::SPR_BAT_PREFIX;
  assign spr_is_sprg = spr[9:2] == ppe_pkg::SPR_SPRG_PREFIX;

  always_comb begin
    result.status      = ppe_pkg::ST_HANDLED;
    result.reg_write   = 1'b0;
    result.reg_index   = item.insn[25:21];
    result.reg_value   = 32'd0;
    result.next_pc     = item.pc + 32'd4;
    msr_next           = msr;
    msr_we             = 1'b0;
    srr0_we            = 1'b0;
    srr1_we            = 1'b0;
    sdr1_we            = 1'b0;
    sprg_we            = 1'b0;
    bat_we             = 1'b0;
    if (!item.is_program_trap || item.mode_64bit) begin
      result.status = ppe_pkg::ST_NOT_EMULATED;
    end else begin
      unique case (op)
        ppe_pkg::OP_MFSR: begin
          // Segment registers never change; entry i holds i.
          result.reg_write = 1'b1;
          result.reg_value = {28'd0, item.insn[19:16]};
        end
        ppe_pkg::OP_MFMSR: begin
          result.reg_write = 1'b1;
          result.reg_value = msr;
        end
        ppe_pkg::OP_MTMSR: begin
          msr_we   = 1'b1;
          msr_next = item.source_value;
        end
        ppe_pkg::OP_MTSPR: begin
          if (spr == ppe_pkg::SPR_SRR0) begin
            srr0_we = 1'b1;
          end else if (spr == ppe_pkg::SPR_SRR1) begin
            srr1_we = 1'b1;
          end else if (spr == ppe_pkg::SPR_SDR1) begin
            sdr1_we = 1'b1;
          end else if (spr_is_bat) begin
            bat_we = 1'b1;
          end else if (spr_is_sprg) begin
            sprg_we = 1'b1;
          end else begin
            result.status = ppe_pkg::ST_BAD_SPR;
          end
        end
        ppe_pkg::OP_MFSPR: begin
          result.reg_write = 1'b1;
          if (spr == ppe_pkg::SPR_SRR0) begin
            result.reg_value = srr0;
          end else if (spr == ppe_pkg::SPR_SRR1) begin
            result.reg_value = srr1;
          end else if (spr == ppe_pkg::SPR_SDR1) begin
            result.reg_value = sdr1;
          end else if (spr == ppe_pkg::SPR_PVR) begin
            result.reg_value = pvr;
          end else if (spr_is_bat) begin
            result.reg_value = bat[spr[3:0]];
          end else if (spr_is_sprg) begin
            result.reg_value = sprg[spr[1:0]];
          end else begin
            result.reg_write = 1'b0;
            result.status    = ppe_pkg::ST_BAD_SPR;
          end
        end
        ppe_pkg::OP_RFI: begin
          msr_we         = 1'b1;
          msr_next       = srr1;
          result.next_pc = srr0;
        end
        default: begin
          result.status = ppe_pkg::ST_UNKNOWN_INSN;
        end
      endcase
    end
    if (result.status != ppe_pkg::ST_HANDLED) begin
      result.next_pc = item.pc;
    end
    result.mmu_changed = msr_we && (ppe_pkg::mmu_on(msr) != ppe_pkg::mmu_on(msr_next));
    result.mmu_enabled = ppe_pkg::mmu_on(msr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvr <= ppe_pkg::PVR_RESET;
    end else if (cfg_we) begin
      pvr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msr  <= ppe_pkg::MSR_RESET;
      srr0 <= 32'd0;
      srr1 <= 32'd0;
      sdr1 <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        sprg[i] <= 32'd0;
      end
      for (int i = 0; i < 16; i++) begin
        bat[i] <= 32'd0;
      end
    end else if (fire) begin
      if (msr_we) begin
        msr <= msr_next;
      end
      if (srr0_we) begin
        srr0 <= item.source_value;
      end
      if (srr1_we) begin
        srr1 <= item.source_value;
      end
      if (sdr1_we) begin
        sdr1 <= item.source_value;
      end
      if (sprg_we) begin
        sprg[spr[1:0]] <= item.source_value;
      end
      if (bat_we) begin
        bat[spr[3:0]] <= item.source_value;
      end
    end
  end

endmodule

### sv/ppe_out_stage.sv
`timescale 1ns / 1ps

module ppe_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ppe_pkg::rsp_t result,
  output logic          can_load,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ppe_pkg::rsp_t rsp
);

  assign can_load = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rsp <= result;
    end
  end

endmodule

### sv/ppc_privileged_insn_emulator_top.sv
`timescale 1ns / 1ps

// Emulates trapped 32-bit PowerPC privileged instructions (mfsr, mfmsr, mtmsr,
// mtspr, mfspr, rfi) against shadow supervisor state, one response per request.
// A request is taken every cycle when the response side keeps up. After the edge
// that accepts it, the request waits in the input register, where the
// instruction is decoded. When it advances, the shadow registers are updated and
// the response is loaded into the response register, where rsp_valid is raised.
// Back-pressure on the response holds the input register, so req_ready drops
// only while both stages are full and rsp_ready is low.
// processor_version may be written only while no request is in flight.
module ppc_privileged_insn_emulator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ppe_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ppe_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data
);

  logic          held_valid;
  ppe_pkg::req_t held;
  ppe_pkg::rsp_t result;
  logic          can_load;
  logic          advance;

  assign advance = held_valid && can_load;

  ppe_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  ppe_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (advance),
    .item     (held),
    .result   (result)
  );

  ppe_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .result    (result),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`include "ppc_privileged_insn_emulator_top_macros.svh"

  `PPE_ASSERT_NOW(a_fail_no_effect, rsp_valid && rsp.status != ppe_pkg::ST_HANDLED, !rsp.reg_write && !rsp.mmu_changed, "failed request has side effects")
  `PPE_ASSERT_NOW(a_fail_keeps_pc, advance && result.status != ppe_pkg::ST_HANDLED, result.next_pc == held.pc, "failed request moved the pc")
  `PPE_ASSERT_NOW(a_ready_only_stalled, !req_ready, held_valid && rsp_valid && !rsp_ready, "request refused without a stall")
  `PPE_ASSERT_NEXT(a_advance_shows, advance, rsp_valid, "advanced request not presented")

endmodule
